// File: src/ili_pkg.sv
// ----------------------------------------------------------------------------
// ili_pkg: shared types and codes for the indexed list engine
// Field widths, op and status codes, and the per-cell shift command.
// ----------------------------------------------------------------------------
`default_nettype none

package ili_pkg;

  localparam int DATA_W           = 32;
  localparam int OP_W             = 3;
  localparam int IDX_W            = 7;
  localparam int ST_W             = 2;
  localparam int LEN_W            = 7;
  localparam int DEFAULT_CAPACITY = 64;

  localparam logic [OP_W-1:0] OP_READ       = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT_AT  = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE_AT  = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  // broadcast to every cell: shift back (insert) or forward (delete)
  typedef struct packed {
    logic ins;
    logic del;
  } cell_op_t;

endpackage

`default_nettype wire

// File: src/ili_ifs.sv
// ----------------------------------------------------------------------------
// ili_ifs: request and response channels of the indexed list engine
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ili_req_if;
  logic                                valid;
  logic                                ready;
  logic        [ili_pkg::OP_W-1:0]     op;
  logic        [ili_pkg::IDX_W-1:0]    index;
  logic signed [ili_pkg::DATA_W-1:0]   value;

  modport source (output valid, op, index, value, input ready);
  modport sink   (input valid, op, index, value, output ready);
endinterface

interface ili_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [ili_pkg::DATA_W-1:0]   read_value;
  logic        [ili_pkg::ST_W-1:0]     status;
  logic        [ili_pkg::LEN_W-1:0]    length;

  modport source (output valid, read_value, status, length, input ready);
  modport sink   (input valid, read_value, status, length, output ready);
endinterface

`default_nettype wire

// File: src/ili_cell.sv
// ----------------------------------------------------------------------------
// ili_cell: one list slot
// Holds one entry; on insert takes the left neighbor or the new value, on
// delete takes the right neighbor. Drives its entry on tap when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module ili_cell #(
  parameter int IDX   = 0,
  parameter int POS_W = 7
) (
  input  wire logic                          clk,
  input  wire ili_pkg::cell_op_t             op,
  input  wire logic [POS_W-1:0]              pos,
  input  wire logic [ili_pkg::DATA_W-1:0]    value,
  input  wire logic [ili_pkg::DATA_W-1:0]    left,
  input  wire logic [ili_pkg::DATA_W-1:0]    right,
  output logic      [ili_pkg::DATA_W-1:0]    data,
  output logic      [ili_pkg::DATA_W-1:0]    tap
);

  localparam logic [POS_W-1:0] MY = POS_W'(IDX);

  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (pos == MY) begin
        data <= value;
      end else if (MY > pos) begin
        data <= left;
      end
    end else if (op.del && (MY >= pos)) begin
      data <= right;
    end
  end

  assign tap = (pos == MY) ? data : '0;

endmodule

`default_nettype wire

// File: src/ili_or_tree.sv
// ----------------------------------------------------------------------------
// ili_or_tree: registered OR reduction of the cell taps
// Binary tree, one register per level.
// ----------------------------------------------------------------------------
`default_nettype none

module ili_or_tree #(
  parameter int N = 64,
  parameter int W = 32
) (
  input  wire logic          clk,
  input  wire logic [W-1:0]  leaf [N],
  output logic      [W-1:0]  root
);

  localparam int P = 1 << $clog2(N);

  // heap order: node 0 is the root, leaves start at P-1
  logic [W-1:0] node [2*P-1];

  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < N) begin : g_used
      assign node[P-1+j] = leaf[j];
    end else begin : g_pad
      assign node[P-1+j] = '0;
    end
  end

  for (genvar i = 0; i < P-1; i++) begin : g_node
    always_ff @(posedge clk) begin
      node[i] <= node[2*i+1] | node[2*i+2];
    end
  end

  assign root = node[0];

endmodule

`default_nettype wire

// File: src/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: ordered list of signed 32-bit values
// Read, push front, push back, insert at and delete at, one response per beat.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one entry each. An insert or a
// delete shifts every cell at or past the target position at the accept
// edge, and the response to it, or to any rejected request, is registered
// at that edge, so such requests are taken back to back while replies
// drain. A valid read selects the target cell and collects it through a
// registered OR tree of clog2(CAPACITY) levels; no further request is taken
// until the read's response is loaded. A request is taken while a response
// still waits, as long as the response register drains in the same cycle.
// Length is reported in 7 bits. Cells have no reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_delete #(
  parameter int CAPACITY = ili_pkg::DEFAULT_CAPACITY
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ili_req_if.sink    req,
  ili_rsp_if.source  rsp
);

  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int CMPW     = (CW > ili_pkg::IDX_W) ? CW : ili_pkg::IDX_W;
  localparam int TREE_LAT = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(TREE_LAT + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WAIT = 1'b1;

  // control
  logic             state, state_next;
  logic [CNT_W-1:0] wait_cnt;
  logic [CW-1:0]    count, count_next;
  logic [CMPW-1:0]  idx_held;

  // response register
  logic                             out_v;
  logic signed [ili_pkg::DATA_W-1:0] out_rd;
  logic        [ili_pkg::ST_W-1:0]   out_st;
  logic        [ili_pkg::LEN_W-1:0]  out_len;

  // decode
  logic                             acc;
  logic                             out_free;
  logic [CMPW-1:0]                  idx_ext, count_ext, pos_in, pos;
  logic                             in_range, ins_pos_ok, full;
  logic                             ins_go, del_go, read_go;
  logic [ili_pkg::ST_W-1:0]         st_imm;
  logic [ili_pkg::DATA_W-1:0]       rd_imm;
  logic                             out_load;
  ili_pkg::cell_op_t                cop;

  logic [ili_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic [ili_pkg::DATA_W-1:0] cell_tap  [CAPACITY];
  logic [ili_pkg::DATA_W-1:0] root;

  assign out_free  = !out_v || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign acc       = req.valid && req.ready;

  assign idx_ext    = CMPW'(req.index);
  assign count_ext  = CMPW'(count);
  assign in_range   = idx_ext < count_ext;
  assign ins_pos_ok = idx_ext <= count_ext;
  assign full       = count == CW'(CAPACITY);

  // per-op decode; status wins in the order index check, then full check
  always_comb begin
    ins_go  = 1'b0;
    del_go  = 1'b0;
    read_go = 1'b0;
    pos_in  = idx_ext;
    st_imm  = ili_pkg::ST_DONE;
    rd_imm  = '0;
    unique case (req.op)
      ili_pkg::OP_READ: begin
        if (in_range) begin
          read_go = 1'b1;
        end else begin
          st_imm = ili_pkg::ST_BAD_INDEX;
          rd_imm = '1;
        end
      end
      ili_pkg::OP_PUSH_FRONT: begin
        pos_in = '0;
        if (full) st_imm = ili_pkg::ST_FULL;
        else      ins_go = 1'b1;
      end
      ili_pkg::OP_PUSH_BACK: begin
        pos_in = count_ext;
        if (full) st_imm = ili_pkg::ST_FULL;
        else      ins_go = 1'b1;
      end
      ili_pkg::OP_INSERT_AT: begin
        if (!ins_pos_ok) st_imm = ili_pkg::ST_BAD_INDEX;
        else if (full)   st_imm = ili_pkg::ST_FULL;
        else             ins_go = 1'b1;
      end
      ili_pkg::OP_DELETE_AT: begin
        if (in_range) del_go = 1'b1;
        else          st_imm = ili_pkg::ST_BAD_INDEX;
      end
      default: begin
        st_imm = ili_pkg::ST_BAD_INDEX;
      end
    endcase
  end

  assign cop.ins = acc && ins_go;
  assign cop.del = acc && del_go;

  // the select bus holds the read index while the tree settles
  assign pos = (state == S_WAIT) ? idx_held : pos_in;

  always_comb begin
    count_next = count;
    if (cop.ins)      count_next = count + CW'(1);
    else if (cop.del) count_next = count - CW'(1);
  end

  // response loads at accept for every request but a valid read, or when the tree is done
  assign out_load = (acc && !read_go) ||
                    ((state == S_WAIT) && (wait_cnt == '0) && out_free);

  always_comb begin
    state_next = state;
    if (acc && read_go)  state_next = S_WAIT;
    else if (state == S_WAIT && out_load) state_next = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      out_v    <= 1'b0;
      wait_cnt <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load)       out_v <= 1'b1;
      else if (rsp.ready) out_v <= 1'b0;
      if (acc && read_go) wait_cnt <= CNT_W'(TREE_LAT - 1);
      else if (wait_cnt != '0) wait_cnt <= wait_cnt - CNT_W'(1);
    end
  end

  // response payload and held read index
  always_ff @(posedge clk) begin
    if (acc) idx_held <= idx_ext;
    if (out_load) begin
      out_len <= ili_pkg::LEN_W'(count_next);
      if (state == S_WAIT) begin
        out_rd <= root;
        out_st <= ili_pkg::ST_DONE;
      end else begin
        out_rd <= rd_imm;
        out_st <= st_imm;
      end
    end
  end

  assign rsp.valid      = out_v;
  assign rsp.read_value = out_rd;
  assign rsp.status     = out_st;
  assign rsp.length     = out_len;

  // cell row: left neighbor feeds inserts, right neighbor feeds deletes
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ili_pkg::DATA_W-1:0] left_d, right_d;
    if (k == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[k-1];
    end
    if (k == CAPACITY-1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[k+1];
    end
    ili_cell #(
      .IDX   (k),
      .POS_W (CMPW)
    ) u_cell (
      .clk   (clk),
      .op    (cop),
      .pos   (pos),
      .value (req.value),
      .left  (left_d),
      .right (right_d),
      .data  (cell_data[k]),
      .tap   (cell_tap[k])
    );
  end

  ili_or_tree #(
    .N (CAPACITY),
    .W (ili_pkg::DATA_W)
  ) u_tree (
    .clk  (clk),
    .leaf (cell_tap),
    .root (root)
  );

`ifndef SYNTH
  // length never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count above capacity");

  // length only moves on an accepted beat
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(count))
    else $error("count moved without a request");

  // a valid read parks the engine until the tree delivers
  a_read_wait: assert property (@(posedge clk) disable iff (rst)
    (acc && read_go) |=> (state == S_WAIT) && !req.ready)
    else $error("read did not wait for the tree");

  // reported length matches the list length after the request
  a_len_match: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_len == ili_pkg::LEN_W'(count)))
    else $error("response length mismatch");
`endif

endmodule

`default_nettype wire

// File: sim/ili_list_checker.sv
// ----------------------------------------------------------------------------
// ili_list_checker: reply predictor and scoreboard for the indexed list engine
// Watches both channels, keeps a shadow copy of the list, and compares every
// reply beat field by field against the oldest predicted reply.
// ----------------------------------------------------------------------------
`default_nettype none

module ili_list_checker #(
  parameter int CAPACITY = ili_pkg::DEFAULT_CAPACITY
) (
  input  wire logic clk,
  input  wire logic rst,
  ili_req_if        req,
  ili_rsp_if        rsp,
  output int        mismatches,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ili_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic        [ST_W-1:0]   status;
    logic        [LEN_W-1:0]  length;
  } reply_t;

  logic signed [DATA_W-1:0] shadow_list [CAPACITY];
  int                       shadow_len;
  reply_t                   awaited_replies [$];

  task automatic report(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one request to the shadow list and returns the reply it earns.
  function automatic reply_t apply_list_request(logic [OP_W-1:0] op,
                                                logic [IDX_W-1:0] idx,
                                                logic signed [DATA_W-1:0] val);
    reply_t r;
    int     pos;
    int     i;
    r.read_value = '0;
    r.status     = ST_DONE;
    pos          = 0;
    case (op)
      OP_READ: begin
        if (idx < shadow_len) begin
          r.read_value = shadow_list[idx];
        end else begin
          r.read_value = -1;
          r.status     = ST_BAD_INDEX;
        end
      end
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
        if (op == OP_PUSH_FRONT) pos = 0;
        else if (op == OP_PUSH_BACK) pos = shadow_len;
        else pos = idx;
        // position check wins over the full check
        if (pos > shadow_len) begin
          r.status = ST_BAD_INDEX;
        end else if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = val;
          shadow_len++;
        end
      end
      OP_DELETE_AT: begin
        if (idx < shadow_len) begin
          for (i = idx; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end else begin
          r.status = ST_BAD_INDEX;
        end
      end
      default: r.status = ST_BAD_INDEX;
    endcase
    r.length = LEN_W'(shadow_len);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      shadow_len = 0;
      mismatches = 0;
      awaited_replies.delete();
    end else begin
      // reply first: a reply beat never belongs to a request taken at this edge
      if (rsp.valid && rsp.ready) begin
        if (awaited_replies.size() == 0) begin
          report($sformatf("reply with nothing pending: value %0d status %0d length %0d",
                           rsp.read_value, rsp.status, rsp.length));
        end else begin
          want = awaited_replies.pop_front();
          if (rsp.read_value !== want.read_value)
            report($sformatf("read_value got %0d, want %0d", rsp.read_value, want.read_value));
          if (rsp.status !== want.status)
            report($sformatf("status got %0d, want %0d", rsp.status, want.status));
          if (rsp.length !== want.length)
            report($sformatf("length got %0d, want %0d", rsp.length, want.length));
        end
      end
      if (req.valid && req.ready)
        awaited_replies.push_back(apply_list_request(req.op, req.index, req.value));
    end
    outstanding = awaited_replies.size();
  end

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: top level for the indexed list engine
// Drives request beats (directed corner cases, then biased random bursts that
// grow the list to full and shrink it back), throttles both channels in
// several phases and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ili_pkg::*;

  localparam int CAPACITY     = DEFAULT_CAPACITY;
  // slowest legal run: ~425 beats, 72% gaps on both sides,
  // one long hold-off; this is many times that
  localparam int CYCLE_LIMIT  = 200000;
  // quiet time after the last reply
  localparam int TAIL_CYCLES  = 20;
  localparam int HOLD_OFF     = 150;
  localparam int PHASE_BEATS  = 100;
  localparam int GROW_RUN     = 80;
  localparam int SHRINK_RUN   = 70;

  // op codes the block does not define; they must come back as bad index
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   cycles;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_cycles    = 0;

  ili_req_if req_ch ();
  ili_rsp_if rsp_ch ();

  indexed_list_insert_delete #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ili_list_checker #(
    .CAPACITY (CAPACITY)
  ) chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hang or a lost reply ends up here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Reply side. A pending hold-off keeps ready low until it runs out;
  // otherwise ready drops at random per the current stall rate.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // One request beat. Returns at the posedge where the beat was taken, with
  // valid still high, so back-to-back beats never toggle valid in one step.
  task automatic offer_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                               logic signed [DATA_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.index <= idx;
    req_ch.value <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Sender goes quiet until every predicted reply has been seen.
  task automatic pause_until_replied();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Biased random beat. Growing bursts are mostly inserts so the list runs
  // into full; shrinking bursts are mostly deletes so it drains toward empty.
  task automatic random_request(bit grow);
    int                       pick;
    int                       spread;
    logic [OP_W-1:0]          op;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] val;
    pick = $urandom_range(99);
    if (pick < 2)
      op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    else if (grow)
      op = (pick < 30) ? OP_PUSH_BACK :
           (pick < 50) ? OP_PUSH_FRONT :
           (pick < 80) ? OP_INSERT_AT :
           (pick < 87) ? OP_DELETE_AT : OP_READ;
    else
      op = (pick < 10) ? OP_PUSH_BACK :
           (pick < 15) ? OP_PUSH_FRONT :
           (pick < 22) ? OP_INSERT_AT :
           (pick < 75) ? OP_DELETE_AT : OP_READ;
    // small positions dominate so short lists still see valid hits
    spread = $urandom_range(99);
    if (spread < 50)      idx = IDX_W'($urandom_range(7));
    else if (spread < 90) idx = IDX_W'($urandom_range(CAPACITY));
    else                  idx = IDX_W'($urandom);
    spread = $urandom_range(99);
    if (spread < 70)      val = $urandom;
    else if (spread < 90) val = DATA_W'($urandom_range(31)) - 16;
    else                  val = (spread < 95) ? 32'sh8000_0000 : 32'sh7fff_ffff;
    offer_request(op, idx, val);
  endtask

  initial begin
    int  phase;
    int  n;
    int  op_code;
    bit  grow;
    int  run_left;

    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op    = OP_READ;
    req_ch.index = '0;
    req_ch.value = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed corner cases, no throttling ----
    offer_request(OP_READ,      7'd0,   32'sd0);          // read on empty list
    offer_request(OP_DELETE_AT, 7'd0,   32'sd0);          // delete on empty list
    offer_request(OP_INSERT_AT, 7'd1,   32'sd9);          // insert past the end
    offer_request(OP_INSERT_AT, 7'd0,   32'sd5);          // insert at end of empty
    offer_request(OP_PUSH_FRONT, 7'd127, 32'sh8000_0000); // most negative value
    offer_request(OP_PUSH_BACK,  7'd127, 32'sh7fff_ffff); // most positive value
    offer_request(OP_INSERT_AT, 7'd2,   -32'sd1);         // insert in the middle
    offer_request(OP_INSERT_AT, 7'd4,   32'sd0);          // insert right at length
    offer_request(OP_INSERT_AT, 7'd6,   32'sd1);          // one past length
    offer_request(OP_INSERT_AT, 7'd127, -32'sd1);         // widest position
    for (n = 0; n < 5; n++) offer_request(OP_READ, IDX_W'(n), 32'sd0);
    offer_request(OP_READ,      7'd5,   32'sd0);          // read at length
    offer_request(OP_READ,      7'd127, -32'sd1);         // read at widest position
    for (op_code = OP_SPARE_FIRST; op_code <= OP_SPARE_LAST; op_code++)
      offer_request(OP_W'(op_code), 7'd127, -32'sd1);     // undefined ops
    offer_request(OP_DELETE_AT, 7'd127, 32'sd0);          // delete far past end
    offer_request(OP_DELETE_AT, 7'd0,   32'sd0);          // delete head
    offer_request(OP_DELETE_AT, 7'd3,   32'sd0);          // delete tail
    offer_request(OP_READ,      7'd1,   32'sd0);
    offer_request(OP_DELETE_AT, 7'd5,   32'sd0);          // delete past end
    pause_until_replied();

    // ---- random bursts, one throttle setting per phase ----
    grow     = 1'b1;
    run_left = GROW_RUN;
    for (phase = 0; phase < 4; phase++) begin
      @(posedge clk);
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (n = 0; n < PHASE_BEATS; n++) begin
        random_request(grow);
        run_left--;
        if (run_left == 0) begin
          grow     = !grow;
          run_left = grow ? GROW_RUN : SHRINK_RUN;
        end
        // long reply hold-off while beats keep coming: the block backs up
        // and must stall its request side
        if (phase == 0 && n == PHASE_BEATS / 2) hold_cycles = HOLD_OFF;
      end
      pause_until_replied();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
src/ili_pkg.sv
src/ili_ifs.sv
src/ili_cell.sv
src/ili_or_tree.sv
src/indexed_list_insert_delete.sv
sim/ili_list_checker.sv
sim/tb.sv
